// ----- rtl/core/okrt_pkg.sv -----
package okrt_pkg;

	localparam int DEPTH     = 16;
	localparam int KEY_W     = 32;
	localparam int VAL_W     = 16;
	localparam int MODE_W    = 3;
	localparam int STAT_W    = 2;
	localparam int OUT_CNT_W = 5;
	localparam int CNT_W     = $clog2(DEPTH + 1);

	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd2;
	localparam logic [MODE_W-1:0] MODE_MODIFY = 3'd3;
	localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd4;

	localparam logic [STAT_W-1:0] RS_OK        = 2'd0;
	localparam logic [STAT_W-1:0] RS_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] RS_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] RS_EMPTY     = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} cmd_t;

	// per-cell view of the occupancy
	typedef struct packed {
		logic             in_use;
		logic             tail;
		logic             last;
		logic [CNT_W-1:0] pos;
	} slot_t;

	// first-match search carried from cell to cell
	typedef struct packed {
		logic             seen;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] pos;
	} chain_t;

endpackage

// ----- rtl/core/okrt_cmd_if.sv -----
interface okrt_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [okrt_pkg::MODE_W-1:0]        mode;
	logic [okrt_pkg::KEY_W-1:0]         key;
	logic [okrt_pkg::VAL_W-1:0]         grade_value;

	modport source (output valid, output mode, output key, output grade_value, input ready);
	modport sink (input valid, input mode, input key, input grade_value, output ready);
endinterface

// ----- rtl/core/okrt_rsp_if.sv -----
interface okrt_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [okrt_pkg::STAT_W-1:0]        result_status;
	logic [okrt_pkg::VAL_W-1:0]         found_value;
	logic [okrt_pkg::OUT_CNT_W-1:0]     found_position;
	logic [okrt_pkg::OUT_CNT_W-1:0]     entry_count;

	modport source (output valid, output result_status, output found_value,
		output found_position, output entry_count, input ready);
	modport sink (input valid, input result_status, input found_value,
		input found_position, input entry_count, output ready);
endinterface

// ----- rtl/core/ordered_keyed_record_table_core.sv -----
// channel | dir | payload                                              | handshake
// cmd     | in  | mode, key, grade_value                               | valid/ready
// rsp     | out | result_status, found_value, found_position, entry_count | valid/ready
//
// per transaction: the accept edge compares the key in every cell at once; the commit
// edge of the update state resolves the first match along the row of cells, shifts or writes
// the records and loads the result register; a new command is taken only after that commit.
// reset clears the record count, the sequencer and the result valid; records are not cleared.
// a result still waiting holds the update cycle; a command is taken while it waits.
module ordered_keyed_record_table_core (
	input  logic        clk,
	input  logic        arst_n,
	okrt_cmd_if.sink    cmd,
	okrt_rsp_if.source  rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_UPD  = 2'd1;
	localparam int         EXT_W  = okrt_pkg::CNT_W + okrt_pkg::OUT_CNT_W;

	logic [1:0]                     phase_q;
	okrt_pkg::cmd_t                 cmd_q;
	logic [okrt_pkg::CNT_W-1:0]     occ_q;
	logic [okrt_pkg::CNT_W-1:0]     occ_nx;
	logic                           accept;
	logic                           commit;
	logic                           found;
	logic [okrt_pkg::STAT_W-1:0]    status_nx;
	logic [okrt_pkg::VAL_W-1:0]     fval_nx;
	logic [okrt_pkg::CNT_W-1:0]     fpos_nx;
	logic [EXT_W-1:0]               occ_ext;
	logic [EXT_W-1:0]               fpos_ext;

	logic                           rsp_valid_q;
	logic [okrt_pkg::STAT_W-1:0]    rsp_status_q;
	logic [okrt_pkg::VAL_W-1:0]     rsp_fval_q;
	logic [okrt_pkg::OUT_CNT_W-1:0] rsp_fpos_q;
	logic [okrt_pkg::OUT_CNT_W-1:0] rsp_count_q;

	okrt_pkg::slot_t                slot     [okrt_pkg::DEPTH];
	okrt_pkg::chain_t               chain    [okrt_pkg::DEPTH+1];
	logic [okrt_pkg::KEY_W-1:0]     rec_key  [okrt_pkg::DEPTH];
	logic [okrt_pkg::VAL_W-1:0]     rec_val  [okrt_pkg::DEPTH];
	logic [okrt_pkg::KEY_W-1:0]     nxt_key  [okrt_pkg::DEPTH];
	logic [okrt_pkg::VAL_W-1:0]     nxt_val  [okrt_pkg::DEPTH];
	logic [okrt_pkg::DEPTH-1:0]     hit_vec;

	assign cmd.ready = (phase_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign commit    = (phase_q == S_UPD) && (!rsp_valid_q || rsp.ready);
	assign chain[0]  = '0;
	assign found     = chain[okrt_pkg::DEPTH].seen;

	for (genvar i = 0; i < okrt_pkg::DEPTH; i++) begin : g_cell
		assign slot[i].in_use = (okrt_pkg::CNT_W'(i) < occ_q);
		assign slot[i].tail   = (occ_q == okrt_pkg::CNT_W'(i));
		assign slot[i].last   = (occ_q == okrt_pkg::CNT_W'(i + 1));
		assign slot[i].pos    = okrt_pkg::CNT_W'(i + 1);
		assign hit_vec[i]     = chain[i+1].seen && !chain[i].seen;

		if (i == okrt_pkg::DEPTH - 1) begin : g_end
			assign nxt_key[i] = '0;
			assign nxt_val[i] = '0;
		end else begin : g_mid
			assign nxt_key[i] = rec_key[i+1];
			assign nxt_val[i] = rec_val[i+1];
		end

		okrt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.compare    (accept),
			.probe_key  (cmd.key),
			.commit     (commit),
			.cmd        (cmd_q),
			.slot       (slot[i]),
			.next_key   (nxt_key[i]),
			.next_value (nxt_val[i]),
			.chain_in   (chain[i]),
			.chain_out  (chain[i+1]),
			.rec_key    (rec_key[i]),
			.rec_value  (rec_val[i])
		);
	end

	always_comb begin
		status_nx = okrt_pkg::RS_OK;
		fval_nx   = '0;
		fpos_nx   = '0;
		occ_nx    = occ_q;
		case (cmd_q.mode)
			okrt_pkg::MODE_INSERT: begin
				if (occ_q == okrt_pkg::CNT_W'(okrt_pkg::DEPTH)) begin
					status_nx = okrt_pkg::RS_FULL;
				end else begin
					occ_nx = occ_q + 1'b1;
				end
			end
			okrt_pkg::MODE_DELETE: begin
				if (occ_q == '0) begin
					status_nx = okrt_pkg::RS_EMPTY;
				end else if (!found) begin
					status_nx = okrt_pkg::RS_NOT_FOUND;
				end else begin
					occ_nx = occ_q - 1'b1;
				end
			end
			okrt_pkg::MODE_LOOKUP: begin
				if (!found) begin
					status_nx = okrt_pkg::RS_NOT_FOUND;
				end else begin
					fval_nx = chain[okrt_pkg::DEPTH].value;
					fpos_nx = chain[okrt_pkg::DEPTH].pos;
				end
			end
			okrt_pkg::MODE_MODIFY: begin
				if (!found) begin
					status_nx = okrt_pkg::RS_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	assign occ_ext  = EXT_W'(occ_nx);
	assign fpos_ext = EXT_W'(fpos_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= S_IDLE;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (phase_q)
				S_IDLE: begin
					if (accept) begin
						phase_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (commit) begin
						phase_q <= S_IDLE;
					end
				end
				default: begin
					phase_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				occ_q       <= occ_nx;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.mode  <= cmd.mode;
			cmd_q.key   <= cmd.key;
			cmd_q.value <= cmd.grade_value;
		end
		if (commit) begin
			rsp_status_q <= status_nx;
			rsp_fval_q   <= fval_nx;
			rsp_fpos_q   <= fpos_ext[okrt_pkg::OUT_CNT_W-1:0];
			rsp_count_q  <= occ_ext[okrt_pkg::OUT_CNT_W-1:0];
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.result_status  = rsp_status_q;
	assign rsp.found_value    = rsp_fval_q;
	assign rsp.found_position = rsp_fpos_q;
	assign rsp.entry_count    = rsp_count_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= okrt_pkg::CNT_W'(okrt_pkg::DEPTH))
		else $error("record count beyond table depth");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == S_UPD) |-> $onehot0(hit_vec))
		else $error("more than one cell claims the first match");

	a_occ_moves_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != $past(occ_q)) |-> $past(commit))
		else $error("record count changed outside an update");

	a_rsp_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(phase_q == S_UPD))
		else $error("result raised without an update cycle");

endmodule

// ----- rtl/core/okrt_cell.sv -----
module okrt_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         compare,
	input  logic [okrt_pkg::KEY_W-1:0]   probe_key,
	input  logic                         commit,
	input  okrt_pkg::cmd_t               cmd,
	input  okrt_pkg::slot_t              slot,
	input  logic [okrt_pkg::KEY_W-1:0]   next_key,
	input  logic [okrt_pkg::VAL_W-1:0]   next_value,
	input  okrt_pkg::chain_t             chain_in,
	output okrt_pkg::chain_t             chain_out,
	output logic [okrt_pkg::KEY_W-1:0]   rec_key,
	output logic [okrt_pkg::VAL_W-1:0]   rec_value
);

	logic [okrt_pkg::KEY_W-1:0] key_q;
	logic [okrt_pkg::VAL_W-1:0] value_q;
	logic                       match_q;
	logic                       hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (compare) begin
			match_q <= slot.in_use && (key_q == probe_key);
		end
	end

	// only the first matching cell along the row claims the hit
	assign hit = match_q && !chain_in.seen;

	always_comb begin
		chain_out.seen  = chain_in.seen || match_q;
		chain_out.value = hit ? value_q : chain_in.value;
		chain_out.pos   = hit ? slot.pos : chain_in.pos;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			case (cmd.mode)
				okrt_pkg::MODE_INSERT: begin
					if (slot.tail) begin
						key_q   <= cmd.key;
						value_q <= cmd.value;
					end
				end
				okrt_pkg::MODE_DELETE: begin
					// cells from the match onwards pull in their neighbour
					if (chain_out.seen && slot.in_use && !slot.last) begin
						key_q   <= next_key;
						value_q <= next_value;
					end
				end
				okrt_pkg::MODE_MODIFY: begin
					if (hit) begin
						value_q <= cmd.value;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rec_key   = key_q;
	assign rec_value = value_q;

endmodule
